// ===== rtl/core/coil_launcher_arm_fire_controller_macros.svh =====
// Assertion macros shared by the checker of the arm/fire controller.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef COIL_LAUNCHER_ARM_FIRE_CONTROLLER_MACROS_SVH
`define COIL_LAUNCHER_ARM_FIRE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLAFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clafc check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLAFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clafc check failed");

`endif

// ===== rtl/core/clafc_pkg.sv =====
// Shared types, codes and reset values of the coil launcher arm/fire controller.
// Used by every module of the block but clafc_store; depends on nothing.
package clafc_pkg;

    // Request codes.
    localparam logic [2:0] REQ_SET_TIMING = 3'd0;
    localparam logic [2:0] REQ_QUERY      = 3'd1;
    localparam logic [2:0] REQ_FIRE       = 3'd2;
    localparam logic [2:0] REQ_ARM        = 3'd3;
    localparam logic [2:0] REQ_DISARM     = 3'd4;
    localparam logic [2:0] REQ_SEQ_DONE   = 3'd5;
    localparam logic [2:0] REQ_SAFETY     = 3'd6;
    localparam logic [2:0] REQ_CHARGE     = 3'd7;

    // Arm modes.
    localparam logic [1:0] ARM_DISARMED = 2'd0;
    localparam logic [1:0] ARM_ARMED    = 2'd1;
    localparam logic [1:0] ARM_FIRING   = 2'd2;

    // Launcher status codes.
    localparam logic [2:0] ST_UNINIT   = 3'd0;
    localparam logic [2:0] ST_DISARMED = 3'd1;
    localparam logic [2:0] ST_FIRING   = 3'd2;
    localparam logic [2:0] ST_READY    = 3'd3;
    localparam logic [2:0] ST_CHARGING = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DISCHARGED_TH = 2'd0;
    localparam logic [1:0] CFG_CHARGED_TH    = 2'd1;
    localparam logic [1:0] CFG_ON_COMP       = 2'd2;
    localparam logic [1:0] CFG_OFF_COMP      = 2'd3;

    // Configuration reset values.
    localparam logic [11:0] DISCHARGED_TH_RST = 12'd3251;
    localparam logic [11:0] CHARGED_TH_RST    = 12'd3491;
    localparam logic [7:0]  ON_COMP_RST       = 8'd2;
    localparam logic [7:0]  OFF_COMP_RST      = 8'd4;

    // Result fields captured when a request is classified, plus its kind.
    typedef struct packed {
        logic       ok;
        logic [2:0] status;
        logic [1:0] arm;
        logic [1:0] sel;
        logic       dis;
        logic       led;
        logic       fire;
    } t_rsp;

    // Launcher status from the interlock state of one launcher.
    function automatic logic [2:0] status_of(input logic all_set, input logic [1:0] arm,
                                             input logic fire_bit, input logic charged);
        logic [2:0] st;
        if (!all_set) begin
            st = ST_UNINIT;
        end else if (arm == ARM_DISARMED) begin
            st = ST_DISARMED;
        end else if (fire_bit) begin
            st = ST_FIRING;
        end else if (charged) begin
            st = ST_READY;
        end else begin
            st = ST_CHARGING;
        end
        return st;
    endfunction

endpackage

// ===== rtl/core/coil_launcher_arm_fire_controller.sv =====
// Arm/fire interlock controller for a coil launcher. Every request gives one
// result except an accepted fire, which gives TIMING_COUNT results carrying the
// launcher's compensated timing words, the last one flagged. A request is
// classified in the cycle of its transfer and queued in a two-entry queue; the
// sequencer then loads its first result from the queue head into the output
// register, from which it is offered. The words of a fire follow at one per
// cycle while the output is not stalled, paced by the single registered read
// port of the timing store. Requests are taken back to back while the queue
// has room; a set-timing request waits while fire words are still to be read.
// The timing store reads as zero after reset through per-entry flags, so there
// is no clearing pass.
// Depends on clafc_pkg, clafc_front, clafc_queue, clafc_back and clafc_store.
module coil_launcher_arm_fire_controller #(
    parameter int LAUNCHER_COUNT = 2,
    parameter int TIMING_COUNT   = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [1:0]  i_launcher_index,
    input  logic [2:0]  i_timing_index,
    input  logic [15:0] i_time_us,
    input  logic [11:0] i_charge_sample,
    input  logic        i_kill_active,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [2:0]  o_launcher_status,
    output logic [1:0]  o_arm_status,
    output logic        o_arm_drive,
    output logic [1:0]  o_select_drive,
    output logic        o_discharge_drive,
    output logic        o_charged_led,
    output logic [15:0] o_timing_word,
    output logic        o_last
);

    localparam int DEPTH = LAUNCHER_COUNT * TIMING_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             push;
    clafc_pkg::t_rsp  push_rsp;
    logic [AW-1:0]    push_base;
    logic             pop;
    logic             q_full;
    logic             q_nonempty;
    clafc_pkg::t_rsp  head_rsp;
    logic [AW-1:0]    head_base;
    logic             q_any_fire;
    logic             back_busy;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [15:0]      wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [15:0]      rd_word;
    logic [DEPTH-1:0] nz;
    clafc_pkg::t_rsp  out_rsp;

    clafc_front #(
        .LC    (LAUNCHER_COUNT),
        .TC    (TIMING_COUNT),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_launcher_index (i_launcher_index),
        .i_timing_index   (i_timing_index),
        .i_time_us        (i_time_us),
        .i_charge_sample  (i_charge_sample),
        .i_kill_active    (i_kill_active),
        .i_q_full         (q_full),
        .i_fire_pend      (q_any_fire || back_busy),
        .o_push           (push),
        .o_push_rsp       (push_rsp),
        .o_push_base      (push_base),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .i_nz             (nz)
    );

    clafc_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_rsp  (push_rsp),
        .i_push_base (push_base),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_nonempty  (q_nonempty),
        .o_head_rsp  (head_rsp),
        .o_head_base (head_base),
        .o_any_fire  (q_any_fire)
    );

    clafc_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_nz      (nz),
        .o_rd_word (rd_word)
    );

    clafc_back #(
        .TC (TIMING_COUNT),
        .AW (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_head_rsp    (head_rsp),
        .i_head_base   (head_base),
        .o_pop         (pop),
        .o_busy        (back_busy),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_word     (rd_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rsp         (out_rsp),
        .o_timing_word (o_timing_word),
        .o_last        (o_last)
    );

    // Result fields from the sequencer's output register.
    assign o_ok              = out_rsp.ok;
    assign o_launcher_status = out_rsp.status;
    assign o_arm_status      = out_rsp.arm;
    assign o_arm_drive       = out_rsp.arm != clafc_pkg::ARM_DISARMED;
    assign o_select_drive    = out_rsp.sel;
    assign o_discharge_drive = out_rsp.dis;
    assign o_charged_led     = out_rsp.led;

endmodule

// ===== rtl/core/clafc_store.sv =====
// Timing word store: a small memory with one write and one registered read port.
// Per-entry nonzero bits double as valid bits so reset reads every word as zero.
module clafc_store #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [15:0]      i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [DEPTH-1:0] o_nz,
    output logic [15:0]      o_rd_word
);

    logic [15:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_nz;
    logic [15:0]      r_rdata;
    logic             r_rd_nz;

    // Nonzero flags; a cleared flag means the entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else if (i_wr_en) begin
            r_nz[i_wr_addr] <= (i_wr_data != 16'd0);
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
            r_rd_nz <= r_nz[i_rd_addr];
        end
    end

    assign o_nz      = r_nz;
    assign o_rd_word = r_rd_nz ? r_rdata : 16'd0;

endmodule

// ===== rtl/core/clafc_front.sv =====
// Front end: takes requests, applies the interlock rules and configuration,
// and pushes one classified command per request. Uses clafc_pkg.
module clafc_front #(
    parameter int LC    = 2,
    parameter int TC    = 5,
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_idx,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_req_type,
    input  logic [1:0]          i_launcher_index,
    input  logic [2:0]          i_timing_index,
    input  logic [15:0]         i_time_us,
    input  logic [11:0]         i_charge_sample,
    input  logic                i_kill_active,
    input  logic                i_q_full,
    input  logic                i_fire_pend,
    output logic                o_push,
    output clafc_pkg::t_rsp     o_push_rsp,
    output logic [AW-1:0]       o_push_base,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [15:0]         o_wr_data,
    input  logic [DEPTH-1:0]    i_nz
);

    localparam logic [DEPTH-1:0] SEG_MASK = DEPTH'((64'd1 << TC) - 64'd1);

    logic [11:0]   r_dis_th;
    logic [11:0]   r_chg_th;
    logic [7:0]    r_on_comp;
    logic [7:0]    r_off_comp;
    logic [1:0]    r_arm;
    logic [LC-1:0] r_flags;
    logic          r_charged;
    logic          r_dis_flag;
    logic [11:0]   r_sample;
    logic          r_led;

    logic [1:0]    n_arm;
    logic [LC-1:0] n_flags;
    logic          n_charged;
    logic          n_dis_flag;
    logic [11:0]   n_sample;
    logic          n_led;

    logic             accept;
    logic             l_ok;
    logic [1:0]       lidx;
    logic [AW-1:0]    base;
    logic [LC-1:0]    lmask;
    logic [7:0]       comp;
    logic             ti_ok;
    logic             set_ok;
    logic [15:0]      wdata;
    logic [AW-1:0]    waddr;
    logic [DEPTH-1:0] nz_after;
    logic             all_set;
    logic             eval_ch;
    logic             samp_ch;
    logic             ok;
    logic             fire;
    logic [LC+1:0]    flags_ext;

    // Launcher decode and timing write check.
    always_comb begin
        accept  = i_in_valid && !o_in_stall;
        l_ok    = (i_launcher_index != 2'd0) && (int'(i_launcher_index) <= LC);
        lidx    = i_launcher_index - 2'd1;
        base    = AW'(int'(lidx) * TC);
        lmask   = LC'(1) << lidx;
        comp    = i_timing_index[0] ? r_off_comp : r_on_comp;
        ti_ok   = int'(i_timing_index) < TC;
        set_ok  = (i_req_type == clafc_pkg::REQ_SET_TIMING) && l_ok && ti_ok &&
                  (i_time_us >= {8'd0, comp}) && (r_arm == clafc_pkg::ARM_DISARMED);
        wdata   = i_time_us - {8'd0, comp};
        waddr   = base + AW'(i_timing_index);
        eval_ch = r_charged ? (r_sample >= r_dis_th) : (r_sample >= r_chg_th);
        samp_ch = r_charged ? (i_charge_sample >= r_dis_th) : (i_charge_sample >= r_chg_th);
    end

    // Nonzero view of the store as it stands after this request.
    always_comb begin
        nz_after = i_nz;
        if (set_ok) begin
            nz_after[waddr] = (wdata != 16'd0);
        end
        all_set = ((nz_after >> base) & SEG_MASK) == SEG_MASK;
    end

    // Interlock rules for each request type.
    always_comb begin
        n_arm      = r_arm;
        n_flags    = r_flags;
        n_charged  = r_charged;
        n_dis_flag = r_dis_flag;
        n_sample   = r_sample;
        n_led      = r_led;
        ok         = 1'b0;
        fire       = 1'b0;
        case (i_req_type)
            clafc_pkg::REQ_SET_TIMING: begin
                ok = set_ok;
            end
            clafc_pkg::REQ_QUERY: begin
                if (l_ok) begin
                    n_charged = eval_ch;
                    ok        = 1'b1;
                end
            end
            clafc_pkg::REQ_FIRE: begin
                if (l_ok && !i_kill_active && r_arm == clafc_pkg::ARM_ARMED) begin
                    n_charged = eval_ch;
                    if (clafc_pkg::status_of(all_set, r_arm, |(r_flags & lmask), eval_ch) ==
                        clafc_pkg::ST_READY) begin
                        n_arm   = clafc_pkg::ARM_FIRING;
                        n_flags = r_flags | lmask;
                        ok      = 1'b1;
                        fire    = 1'b1;
                    end
                end
            end
            clafc_pkg::REQ_ARM: begin
                if (!i_kill_active && r_arm == clafc_pkg::ARM_DISARMED) begin
                    n_arm = clafc_pkg::ARM_ARMED;
                    ok    = 1'b1;
                end
            end
            clafc_pkg::REQ_DISARM: begin
                if (r_arm == clafc_pkg::ARM_ARMED) begin
                    n_arm = clafc_pkg::ARM_DISARMED;
                    ok    = 1'b1;
                end
            end
            clafc_pkg::REQ_SEQ_DONE: begin
                n_flags = '0;
                n_arm   = clafc_pkg::ARM_DISARMED;
                ok      = 1'b1;
            end
            clafc_pkg::REQ_SAFETY: begin
                n_flags    = '0;
                n_arm      = clafc_pkg::ARM_DISARMED;
                n_dis_flag = 1'b1;
                ok         = 1'b1;
            end
            default: begin
                n_sample  = i_charge_sample;
                n_charged = samp_ch;
                n_led     = samp_ch;
                ok        = 1'b1;
            end
        endcase
    end

    // Result snapshot taken from the state after the request.
    always_comb begin
        flags_ext         = {2'b00, n_flags};
        o_push_rsp.ok     = ok;
        o_push_rsp.status = l_ok ? clafc_pkg::status_of(all_set, n_arm, |(n_flags & lmask),
                                                        n_charged)
                                 : clafc_pkg::ST_UNINIT;
        o_push_rsp.arm    = n_arm;
        o_push_rsp.sel    = flags_ext[1:0];
        o_push_rsp.dis    = n_dis_flag;
        o_push_rsp.led    = n_led;
        o_push_rsp.fire   = fire;
    end

    // Hold off when the queue is full, and hold timing writes while fire words are pending.
    assign o_in_stall  = i_q_full || (i_fire_pend && i_req_type == clafc_pkg::REQ_SET_TIMING);
    assign o_push      = accept;
    assign o_push_base = base;
    assign o_wr_en     = accept && set_ok;
    assign o_wr_addr   = waddr;
    assign o_wr_data   = wdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dis_th   <= clafc_pkg::DISCHARGED_TH_RST;
            r_chg_th   <= clafc_pkg::CHARGED_TH_RST;
            r_on_comp  <= clafc_pkg::ON_COMP_RST;
            r_off_comp <= clafc_pkg::OFF_COMP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                clafc_pkg::CFG_DISCHARGED_TH: r_dis_th   <= i_cfg_wdata;
                clafc_pkg::CFG_CHARGED_TH:    r_chg_th   <= i_cfg_wdata;
                clafc_pkg::CFG_ON_COMP:       r_on_comp  <= i_cfg_wdata[7:0];
                clafc_pkg::CFG_OFF_COMP:      r_off_comp <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Interlock state, updated on each request transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm      <= clafc_pkg::ARM_DISARMED;
            r_flags    <= '0;
            r_charged  <= 1'b0;
            r_dis_flag <= 1'b0;
            r_sample   <= 12'd0;
            r_led      <= 1'b0;
        end else if (accept) begin
            r_arm      <= n_arm;
            r_flags    <= n_flags;
            r_charged  <= n_charged;
            r_dis_flag <= n_dis_flag;
            r_sample   <= n_sample;
            r_led      <= n_led;
        end
    end

endmodule

// ===== rtl/core/clafc_queue.sv =====
// Two-entry command queue between the front end and the result sequencer.
// Holds classified commands (clafc_pkg::t_rsp) with their store base address.
module clafc_queue #(
    parameter int AW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clafc_pkg::t_rsp i_push_rsp,
    input  logic [AW-1:0]   i_push_base,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output clafc_pkg::t_rsp o_head_rsp,
    output logic [AW-1:0]   o_head_base,
    output logic            o_any_fire
);

    clafc_pkg::t_rsp r_rsp  [2];
    logic [AW-1:0]   r_base [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic [1:0]      occ;

    // Occupancy of each slot, for the pending fire check.
    always_comb begin
        occ[0]     = (r_count == 2'd2) || (r_count == 2'd1 && !r_rptr);
        occ[1]     = (r_count == 2'd2) || (r_count == 2'd1 && r_rptr);
        o_any_fire = (occ[0] && r_rsp[0].fire) || (occ[1] && r_rsp[1].fire);
    end

    assign o_full      = r_count == 2'd2;
    assign o_nonempty  = r_count != 2'd0;
    assign o_head_rsp  = r_rsp[r_rptr];
    assign o_head_base = r_base[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rsp[r_wptr]  <= i_push_rsp;
            r_base[r_wptr] <= i_push_base;
        end
    end

endmodule

// ===== rtl/core/clafc_back.sv =====
// Result sequencer: turns queued commands into result transfers, reading the
// timing words of a fire from the store one per cycle unless the output stalls. Uses clafc_pkg.
module clafc_back #(
    parameter int TC = 5,
    parameter int AW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_nonempty,
    input  clafc_pkg::t_rsp i_head_rsp,
    input  logic [AW-1:0]   i_head_base,
    output logic            o_pop,
    output logic            o_busy,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  logic [15:0]     i_rd_word,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output clafc_pkg::t_rsp o_rsp,
    output logic [15:0]     o_timing_word,
    output logic            o_last
);

    localparam int CW = $clog2(TC + 1);

    logic            r_valid;
    logic            r_busy;
    clafc_pkg::t_rsp r_rsp;
    logic            r_last;
    logic            r_from_store;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_addr;
    logic            adv;
    logic            last_word;

    // Output register is free when empty or being transferred.
    always_comb begin
        adv       = !r_valid || !i_out_stall;
        last_word = r_cnt == CW'(TC - 1);
        o_pop     = adv && !r_busy && i_q_nonempty;
        o_rd_en   = adv && (r_busy || (i_q_nonempty && i_head_rsp.fire));
        o_rd_addr = r_busy ? r_addr : i_head_base;
    end

    // Output valid and fire sequence control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else if (adv) begin
            if (r_busy) begin
                r_valid <= 1'b1;
                if (last_word) begin
                    r_busy <= 1'b0;
                end
            end else if (i_q_nonempty) begin
                r_valid <= 1'b1;
                r_busy  <= i_head_rsp.fire && (TC > 1);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result fields and word counter.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_busy) begin
                r_last <= last_word;
                r_cnt  <= r_cnt + CW'(1);
                r_addr <= r_addr + AW'(1);
            end else if (i_q_nonempty) begin
                r_rsp        <= i_head_rsp;
                r_from_store <= i_head_rsp.fire;
                r_last       <= !i_head_rsp.fire || (TC == 1);
                r_cnt        <= CW'(1);
                r_addr       <= i_head_base + AW'(1);
            end
        end
    end

    assign o_busy        = r_busy;
    assign o_out_valid   = r_valid;
    assign o_rsp         = r_rsp;
    assign o_last        = r_last;
    assign o_timing_word = r_from_store ? i_rd_word : 16'd0;

endmodule

// ===== rtl/core/clafc_checker.sv =====
// Port-level checks of the arm/fire controller, bound to its top level.
// Depends on the assertion macros header and clafc_pkg.
`include "coil_launcher_arm_fire_controller_macros.svh"

module clafc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_ok,
    input logic [2:0]  o_launcher_status,
    input logic [1:0]  o_arm_status,
    input logic        o_arm_drive,
    input logic [15:0] o_timing_word
);

    // A stalled result stays offered.
    `CLAFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A nonzero timing word only comes from an accepted fire.
    `CLAFC_ASSERT_SAME(a_word_fire, i_clk, i_rst_n, o_out_valid && o_timing_word != 16'd0, o_ok && o_arm_status == clafc_pkg::ARM_FIRING && o_launcher_status == clafc_pkg::ST_FIRING)

    // The arm pin follows the arm status.
    `CLAFC_ASSERT_SAME(a_arm_pin, i_clk, i_rst_n, o_out_valid, o_arm_drive == (o_arm_status != clafc_pkg::ARM_DISARMED))

    // A firing launcher status needs the controller to be firing.
    `CLAFC_ASSERT_SAME(a_status_arm, i_clk, i_rst_n, o_out_valid && o_launcher_status == clafc_pkg::ST_FIRING, o_arm_status == clafc_pkg::ARM_FIRING)

endmodule

bind coil_launcher_arm_fire_controller clafc_checker u_clafc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_ok              (o_ok),
    .o_launcher_status (o_launcher_status),
    .o_arm_status      (o_arm_status),
    .o_arm_drive       (o_arm_drive),
    .o_timing_word     (o_timing_word)
);
